/* rtl/ppg_pkg.sv */
// Shared types, constants and the sine table of the plasma pixel generator.
package ppg_pkg;

   // Field widths
   localparam int COORD_W  = 11;
   localparam int LIMIT_W  = 13;
   localparam int INDEX_W  = 7;
   localparam int COLOUR_W = 8;
   localparam int PHASE_W  = 8;

   // Default frame limits
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   // Item action codes
   localparam logic [1:0] ACTION_BEGIN = 2'd0;
   localparam logic [1:0] ACTION_PIXEL = 2'd1;
   localparam logic [1:0] ACTION_END   = 2'd2;

   // Constant added to the four wave samples
   localparam logic [9:0] PLASMA_BIAS = 10'd50;

   // Per-frame phase steps, mod 256
   localparam logic [PHASE_W-1:0] ROW_A_STEP    = 8'd252;
   localparam logic [PHASE_W-1:0] ROW_B_STEP    = 8'd3;
   localparam logic [PHASE_W-1:0] COLUMN_A_STEP = 8'd254;
   localparam logic [PHASE_W-1:0] COLUMN_B_STEP = 8'd1;

   typedef logic [PHASE_W-1:0] wave_table_type [0:255];

   // round(32 sin(k pi / 129)) for k = 0..64
   localparam logic [5:0] QUARTER_WAVE [0:64] = '{
       6'd0,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd5,  6'd5,
       6'd6,  6'd7,  6'd8,  6'd8,  6'd9,  6'd10, 6'd11, 6'd11,
       6'd12, 6'd13, 6'd14, 6'd14, 6'd15, 6'd16, 6'd16, 6'd17,
       6'd18, 6'd18, 6'd19, 6'd20, 6'd20, 6'd21, 6'd21, 6'd22,
       6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26, 6'd26,
       6'd26, 6'd27, 6'd27, 6'd28, 6'd28, 6'd28, 6'd29, 6'd29,
       6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31, 6'd31,
       6'd31, 6'd31, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32,
       6'd32
   };

   // Build the 256-entry wave table at elaboration: 30 + 32 sin, wrapped to 8 bits
   function automatic wave_table_type build_wave_table();
      wave_table_type t;
      int k;
      int m;
      int val;
      for (int i = 0; i < 256; i++) begin
         k = (i <= 129) ? i : i - 129;
         m = (k <= 129 - k) ? k : 129 - k;
         val = int'(QUARTER_WAVE[m]);
         if (i <= 129) begin
            t[i] = PHASE_W'(30 + val);
         end else begin
            t[i] = PHASE_W'(30 - val);
         end
      end
      return t;
   endfunction

   localparam wave_table_type WAVE_TABLE = build_wave_table();

endpackage

/* rtl/ppg_colour.sv */
// Gradient palette lookup with palette cycling offset and doubling.
module ppg_colour
   import ppg_pkg::*;
(
   input  logic [INDEX_W-1:0]  palette_index,
   input  logic [COLOUR_W-1:0] palette_offset,
   output logic [COLOUR_W-1:0] red,
   output logic [COLOUR_W-1:0] green,
   output logic [COLOUR_W-1:0] blue
);

   logic [COLOUR_W-1:0] ramp;
   logic [COLOUR_W-1:0] base_red;
   logic [COLOUR_W-1:0] base_green;
   logic [COLOUR_W-1:0] base_blue;
   logic [COLOUR_W-1:0] sum_red;
   logic [COLOUR_W-1:0] sum_green;
   logic [COLOUR_W-1:0] sum_blue;

   // Four times the position within the half; 255 minus it is its complement
   assign ramp = {palette_index[5:0], 2'b00};

   // Blue to green in the lower half, green to red in the upper half
   always_comb begin
      if (palette_index[6]) begin
         base_red   = ramp;
         base_green = ~ramp;
         base_blue  = '0;
      end else begin
         base_red   = '0;
         base_green = ramp;
         base_blue  = ~ramp;
      end
   end

   // Add the cycling offset mod 256, then double mod 256
   assign sum_red   = base_red + palette_offset;
   assign sum_green = base_green + palette_offset;
   assign sum_blue  = base_blue + palette_offset;

   assign red   = {sum_red[COLOUR_W-2:0], 1'b0};
   assign green = {sum_green[COLOUR_W-2:0], 1'b0};
   assign blue  = {sum_blue[COLOUR_W-2:0], 1'b0};

endmodule

/* rtl/plasma_pixel_generator.sv */
// Plasma pixel generator: four-stage pipeline from pixel coordinates to colour.
//
// Input channel (req_): one item per transfer. A begin-frame item steps the
// palette offset, an end-frame item steps the four wave phases; neither gives
// a result. A pixel item inside the frame gives one result on the rsp_
// channel; a pixel outside MAX_WIDTH x MAX_HEIGHT and action code 3 are
// dropped without effect.
// Pipeline: ROM addresses, wave samples, plasma index, colour. A result is
// registered in s1, s2, s3 and the output stage in turn before rsp_ shows it,
// and items are taken at one per cycle for as long as the receiver keeps up.
// Frame items act on the phases and offset at their own transfer, so every
// pixel uses the values in force when it was accepted.
// Each stage holds its item while the next is full and stalled; empty stages
// still fill, so up to four results may be parked before req_stall rises.
// req_stall follows rsp_stall combinationally through the stage chain.
// Reset clears all valid bits, the four phases and the palette offset.
module plasma_pixel_generator
   import ppg_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [COORD_W-1:0]  req_pixel_x,
   input  logic [COORD_W-1:0]  req_pixel_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_palette_index,
   output logic [COLOUR_W-1:0] rsp_red,
   output logic [COLOUR_W-1:0] rsp_green,
   output logic [COLOUR_W-1:0] rsp_blue
);

   localparam logic [LIMIT_W-1:0] WIDTH_LIMIT  = LIMIT_W'(MAX_WIDTH);
   localparam logic [LIMIT_W-1:0] HEIGHT_LIMIT = LIMIT_W'(MAX_HEIGHT);

   // Frame state
   logic [PHASE_W-1:0]  row_phase_a_ff, row_phase_a_in;
   logic [PHASE_W-1:0]  row_phase_b_ff, row_phase_b_in;
   logic [PHASE_W-1:0]  column_phase_a_ff, column_phase_a_in;
   logic [PHASE_W-1:0]  column_phase_b_ff, column_phase_b_in;
   logic [COLOUR_W-1:0] palette_offset_ff, palette_offset_in;

   // Pipeline stages
   logic                          s1_valid_ff, s1_valid_in;
   logic [3:0][PHASE_W-1:0]       s1_addr_ff, s1_addr_in;
   logic [COLOUR_W-1:0]           s1_offset_ff;
   logic                          s2_valid_ff;
   logic [3:0][PHASE_W-1:0]       s2_sample_ff, s2_sample_in;
   logic [COLOUR_W-1:0]           s2_offset_ff;
   logic                          s3_valid_ff;
   logic [INDEX_W-1:0]            s3_index_ff, s3_index_in;
   logic [COLOUR_W-1:0]           s3_offset_ff;
   logic                          rsp_valid_ff;
   logic [INDEX_W-1:0]            rsp_index_ff;
   logic [COLOUR_W-1:0]           rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [COLOUR_W-1:0]           red_in, green_in, blue_in;

   logic rsp_ready, s3_ready, s2_ready, s1_ready;
   logic req_transfer, in_frame;
   logic [9:0] plasma_sum;

   // Stage readiness: a stage loads when empty or when its item moves on
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign req_transfer = req_valid && s1_ready;
   assign in_frame = ({2'b00, req_pixel_x} < WIDTH_LIMIT) &&
                     ({2'b00, req_pixel_y} < HEIGHT_LIMIT);

   // Step the frame state on begin- and end-frame transfers; let in-frame pixels in
   always_comb begin
      row_phase_a_in    = row_phase_a_ff;
      row_phase_b_in    = row_phase_b_ff;
      column_phase_a_in = column_phase_a_ff;
      column_phase_b_in = column_phase_b_ff;
      palette_offset_in = palette_offset_ff;
      s1_valid_in       = 1'b0;
      if (req_transfer) begin
         unique case (req_action)
            ACTION_BEGIN: begin
               palette_offset_in = palette_offset_ff + 8'd1;
            end
            ACTION_END: begin
               row_phase_a_in    = row_phase_a_ff + ROW_A_STEP;
               row_phase_b_in    = row_phase_b_ff + ROW_B_STEP;
               column_phase_a_in = column_phase_a_ff + COLUMN_A_STEP;
               column_phase_b_in = column_phase_b_ff + COLUMN_B_STEP;
            end
            ACTION_PIXEL: begin
               s1_valid_in = in_frame;
            end
            default: begin
               s1_valid_in = 1'b0;
            end
         endcase
      end
   end

   // Stage 1: wave ROM addresses, all mod 256
   assign s1_addr_in[0] = column_phase_a_ff + req_pixel_x[7:0];
   assign s1_addr_in[1] = column_phase_b_ff + {req_pixel_x[6:0], 1'b0};
   assign s1_addr_in[2] = row_phase_a_ff + req_pixel_y[7:0] + {req_pixel_y[6:0], 1'b0};
   assign s1_addr_in[3] = row_phase_b_ff + {req_pixel_y[5:0], 2'b00};

   // Stage 2: four table reads
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         s2_sample_in[i] = WAVE_TABLE[s1_addr_ff[i]];
      end
   end

   // Stage 3: sum with bias, keep seven bits
   assign plasma_sum = PLASMA_BIAS + {2'b00, s2_sample_ff[0]} + {2'b00, s2_sample_ff[1]}
                     + {2'b00, s2_sample_ff[2]} + {2'b00, s2_sample_ff[3]};
   assign s3_index_in = plasma_sum[INDEX_W-1:0];

   // Stage 4: palette and cycling
   ppg_colour u_colour (
      .palette_index  (s3_index_ff),
      .palette_offset (s3_offset_ff),
      .red            (red_in),
      .green          (green_in),
      .blue           (blue_in)
   );

   // Frame state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         row_phase_a_ff    <= '0;
         row_phase_b_ff    <= '0;
         column_phase_a_ff <= '0;
         column_phase_b_ff <= '0;
         palette_offset_ff <= '0;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         s3_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         row_phase_a_ff    <= row_phase_a_in;
         row_phase_b_ff    <= row_phase_b_in;
         column_phase_a_ff <= column_phase_a_in;
         column_phase_b_ff <= column_phase_b_in;
         palette_offset_ff <= palette_offset_in;
         if (s1_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Payload: advance with each stage, hold while stalled
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_addr_ff   <= s1_addr_in;
         s1_offset_ff <= palette_offset_ff;
      end
      if (s2_ready) begin
         s2_sample_ff <= s2_sample_in;
         s2_offset_ff <= s1_offset_ff;
      end
      if (s3_ready) begin
         s3_index_ff  <= s3_index_in;
         s3_offset_ff <= s2_offset_ff;
      end
      if (rsp_ready) begin
         rsp_index_ff <= s3_index_ff;
         rsp_red_ff   <= red_in;
         rsp_green_ff <= green_in;
         rsp_blue_ff  <= blue_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;
   assign rsp_red           = rsp_red_ff;
   assign rsp_green         = rsp_green_ff;
   assign rsp_blue          = rsp_blue_ff;

   // Frame items never enter the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_action != ACTION_PIXEL) |=> !s1_valid_ff)
      else $error("frame item entered the pipeline");

   // An in-frame pixel always enters stage 1
   assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_action == ACTION_PIXEL && in_frame) |=> s1_valid_ff)
      else $error("pixel transfer lost at stage 1");

   // A begin-frame transfer steps the offset by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_action == ACTION_BEGIN)
      |=> (palette_offset_ff == $past(palette_offset_ff) + 8'd1))
      else $error("palette offset not stepped");

   // A blocked stage 3 keeps its item
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !rsp_ready) |=> (s3_valid_ff && $stable(s3_index_ff)))
      else $error("stage 3 item changed under stall");

   // Pixels do not change the palette offset, row phase A or column phase B
   assert property (@(posedge clock) disable iff (reset)
      (req_transfer && req_action == ACTION_PIXEL)
      |=> ($stable(palette_offset_ff) && $stable(row_phase_a_ff)
           && $stable(column_phase_b_ff)))
      else $error("pixel altered frame state");

endmodule

/* tb/tb_plasma_pixel_generator.sv */
// Self-checking testbench for the plasma pixel generator: directed table, then random frames.
module tb_plasma_pixel_generator
   import ppg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Action code that the block drops without effect
   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   // Cycles without any transfer before the run is abandoned
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 1000;

   // round(32 sin(k pi / 129)) for k = 0..64
   localparam logic [5:0] SINE_QUARTER [0:64] = '{
       6'd0,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd5,  6'd5,
       6'd6,  6'd7,  6'd8,  6'd8,  6'd9,  6'd10, 6'd11, 6'd11,
       6'd12, 6'd13, 6'd14, 6'd14, 6'd15, 6'd16, 6'd16, 6'd17,
       6'd18, 6'd18, 6'd19, 6'd20, 6'd20, 6'd21, 6'd21, 6'd22,
       6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd25, 6'd26, 6'd26,
       6'd26, 6'd27, 6'd27, 6'd28, 6'd28, 6'd28, 6'd29, 6'd29,
       6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd31, 6'd31, 6'd31,
       6'd31, 6'd31, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32,
       6'd32
   };

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } plasma_colour_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      bit                 typed;
      plasma_colour_type  colour;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 20;

   // Directed items; typed colours are read straight off the formula
   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{ACTION_PIXEL,  11'd0,    11'd0,    1'b1, '{7'd42, 8'd0, 8'd80, 8'd174}},
      '{ACTION_PIXEL,  11'd2047, 11'd2047, 1'b0, '0},
      '{ACTION_PIXEL,  11'd2047, 11'd0,    1'b0, '0},
      '{ACTION_PIXEL,  11'd0,    11'd2047, 1'b0, '0},
      '{ACTION_UNUSED, 11'd2047, 11'd2047, 1'b0, '0},
      '{ACTION_UNUSED, 11'd0,    11'd0,    1'b0, '0},
      '{ACTION_BEGIN,  11'd0,    11'd0,    1'b0, '0},
      '{ACTION_PIXEL,  11'd0,    11'd0,    1'b1, '{7'd42, 8'd2, 8'd82, 8'd176}},
      '{ACTION_PIXEL,  11'd1365, 11'd682,  1'b0, '0},
      '{ACTION_PIXEL,  11'd682,  11'd1365, 1'b0, '0},
      '{ACTION_END,    11'd2047, 11'd2047, 1'b0, '0},
      '{ACTION_PIXEL,  11'd0,    11'd0,    1'b0, '0},
      '{ACTION_PIXEL,  11'd43,   11'd86,   1'b0, '0},
      '{ACTION_BEGIN,  11'd2047, 11'd2047, 1'b0, '0},
      '{ACTION_END,    11'd0,    11'd0,    1'b0, '0},
      '{ACTION_PIXEL,  11'd129,  11'd129,  1'b0, '0},
      '{ACTION_PIXEL,  11'd255,  11'd255,  1'b0, '0},
      '{ACTION_PIXEL,  11'd256,  11'd1024, 1'b0, '0},
      '{ACTION_END,    11'd1024, 11'd256,  1'b0, '0},
      '{ACTION_PIXEL,  11'd1,    11'd1,    1'b0, '0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_action = ACTION_BEGIN;
   logic [COORD_W-1:0]  req_pixel_x = '0;
   logic [COORD_W-1:0]  req_pixel_y = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_palette_index;
   logic [COLOUR_W-1:0] rsp_red;
   logic [COLOUR_W-1:0] rsp_green;
   logic [COLOUR_W-1:0] rsp_blue;

   // Typed expectation travelling alongside the current request
   bit                  req_typed = 1'b0;
   plasma_colour_type   req_typed_colour = '0;

   // Predictor state
   logic [7:0]          sine_lut [0:255];
   logic [7:0]          row_a, row_b, col_a, col_b;
   logic [7:0]          hue_offset;
   plasma_colour_type   pending_colours [$];

   int                  mismatches = 0;
   int                  idle_cycles = 0;
   int                  calm_items = 0;

   plasma_pixel_generator u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_palette_index (rsp_palette_index),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue)
   );

   always #10 clock = ~clock;

   // Fill the sine table and clear the phases and offset as reset does
   initial begin : sine_fill
      int k;
      int fold;
      for (int i = 0; i < 256; i++) begin
         k = (i <= 129) ? i : i - 129;
         fold = (k <= 64) ? k : 129 - k;
         if (i <= 129) begin
            sine_lut[i] = 8'(30 + int'(SINE_QUARTER[fold]));
         end else begin
            sine_lut[i] = 8'(30 - int'(SINE_QUARTER[fold]));
         end
      end
      row_a = '0;
      row_b = '0;
      col_a = '0;
      col_b = '0;
      hue_offset = '0;
   end

   // Add the cycling offset, then double, both mod 256
   function automatic logic [7:0] cycle_shade(input int c);
      logic [7:0] t;
      t = 8'(c + int'(hue_offset));
      return {t[6:0], 1'b0};
   endfunction

   // Colour of one pixel under the current phases and offset
   function automatic plasma_colour_type plasma_colour(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
      plasma_colour_type c;
      int sum;
      int p;
      int r, g, b;
      sum = 50 + int'(sine_lut[8'(int'(col_a) + int'(x))])
               + int'(sine_lut[8'(int'(col_b) + 2 * int'(x))])
               + int'(sine_lut[8'(int'(row_a) + 3 * int'(y))])
               + int'(sine_lut[8'(int'(row_b) + 4 * int'(y))]);
      p = sum & 'h7F;
      if (p < 64) begin
         r = 0;
         g = 4 * p;
         b = 255 - 4 * p;
      end else begin
         r = 4 * (p - 64);
         g = 255 - 4 * (p - 64);
         b = 0;
      end
      c.index = INDEX_W'(p);
      c.red   = cycle_shade(r);
      c.green = cycle_shade(g);
      c.blue  = cycle_shade(b);
      return c;
   endfunction

   task automatic report_mismatch(input string what, input plasma_colour_type want,
                                  input plasma_colour_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %0s: expected idx %0d rgb %0d %0d %0d, got idx %0d rgb %0d %0d %0d",
                  $realtime, what, want.index, want.red, want.green, want.blue,
                  got.index, got.red, got.green, got.blue);
      end
   endtask

   // Predict on every request transfer, check on every result transfer
   always @(posedge clock) begin : colour_check
      plasma_colour_type got;
      plasma_colour_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            case (req_action)
               ACTION_BEGIN: hue_offset <= hue_offset + 8'd1;
               ACTION_END: begin
                  row_a <= row_a - 8'd4;
                  row_b <= row_b + 8'd3;
                  col_a <= col_a - 8'd2;
                  col_b <= col_b + 8'd1;
               end
               ACTION_PIXEL: begin
                  if (int'(req_pixel_x) < DEF_MAX_WIDTH && int'(req_pixel_y) < DEF_MAX_HEIGHT)
                  begin
                     pending_colours.push_back(req_typed ? req_typed_colour
                                                         : plasma_colour(req_pixel_x,
                                                                         req_pixel_y));
                  end
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_palette_index, rsp_red, rsp_green, rsp_blue};
            if (pending_colours.size() == 0) begin
               report_mismatch("result with nothing expected", '0, got);
            end else begin
               want = pending_colours.pop_front();
               if (got != want) begin
                  report_mismatch("colour mismatch", want, got);
               end
            end
         end
      end
   end

   // Abandon the run when nothing transfers for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("plasma_pixel_generator regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver pacing: bursts of acceptance with stalls, mostly short
   initial begin : receiver_pacing
      int run;
      int hold;
      forever begin
         run = ($urandom_range(0, 99) < 10) ? $urandom_range(50, 150) : $urandom_range(1, 8);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
         rsp_stall <= 1'b1;
         repeat (hold) @(posedge clock);
      end
   end

   // Gap before the next item: mostly none, some short, a few long, with calm stretches
   function automatic int pick_gap();
      int r;
      if (calm_items > 0) begin
         calm_items--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_items = $urandom_range(20, 60);
      end
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Offer one item and hold it until it transfers
   task automatic send_item(input logic [1:0] action, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input bit typed = 1'b0,
                            input plasma_colour_type colour = '0);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_pixel_x      <= x;
      req_pixel_y      <= y;
      req_typed        <= typed;
      req_typed_colour <= colour;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] any_coord();
      return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
   endfunction

   initial begin : stimulus
      int sent;
      int pixels;
      bit paused;
      logic [1:0] act;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col0;
      sent = 0;
      paused = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(DIRECTED[i].action, DIRECTED[i].x, DIRECTED[i].y,
                   DIRECTED[i].typed, DIRECTED[i].colour);
      end

      // Random part: mostly whole frames, some stray and unused items
      while (sent < RANDOM_ITEMS) begin
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            // hold the sender until every colour is back
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_colours.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 80) begin
            pixels = $urandom_range(1, 40);
            row  = any_coord();
            col0 = any_coord();
            send_item(ACTION_BEGIN, any_coord(), any_coord());
            for (int j = 0; j < pixels; j++) begin
               if ($urandom_range(0, 1) == 0) begin
                  send_item(ACTION_PIXEL, col0 + COORD_W'(j), row);
               end else begin
                  send_item(ACTION_PIXEL, any_coord(), any_coord());
               end
            end
            send_item(ACTION_END, any_coord(), any_coord());
            sent += pixels + 2;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               act = 2'($urandom_range(0, 3));
               send_item(act, any_coord(), any_coord());
               if (act != ACTION_UNUSED) begin
                  sent++;
               end
            end
         end
      end

      // Drain and let the pipeline settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_colours.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("plasma_pixel_generator regression: pass");
      end else begin
         $display("plasma_pixel_generator regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ppg_pkg.sv
rtl/ppg_colour.sv
rtl/plasma_pixel_generator.sv
tb/tb_plasma_pixel_generator.sv
